// ===== rtl/core/rau_pkg.sv =====
package rau_pkg;
	localparam int WORD_BITS = 32;
	localparam int MAG_BITS = 64;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_CMP = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_DIV_ZERO = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic [MAG_BITS-1:0] quot;
		logic [MAG_BITS-1:0] rem;
	} div_res_t;
endpackage

// ===== rtl/core/rau_divider.sv =====
module rau_divider
	import rau_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MAG_BITS-1:0] dividend,
	input  logic [MAG_BITS-1:0] divisor,
	output logic                done,
	output div_res_t            res
);
	logic [MAG_BITS-1:0] quot_q, rem_q, dvs_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic [MAG_BITS:0] trial;
	logic [MAG_BITS:0] shifted;

	always_comb begin
		shifted = {rem_q, quot_q[MAG_BITS-1]};
		trial = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'(MAG_BITS);
				quot_q <= dividend;
				rem_q <= '0;
				dvs_q <= divisor;
			end else if (busy_q) begin
				if (!trial[MAG_BITS]) begin
					rem_q <= trial[MAG_BITS-1:0];
					quot_q <= {quot_q[MAG_BITS-2:0], 1'b1};
				end else begin
					rem_q <= shifted[MAG_BITS-1:0];
					quot_q <= {quot_q[MAG_BITS-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	assign res.quot = quot_q;
	assign res.rem = rem_q;
endmodule

// ===== rtl/core/rational_arithmetic_unit.sv =====
// Rational arithmetic unit.
// Input stream s_axis: one word per operation, two fractions and an op code.
// Output stream m_axis: one word per input word, reduced fraction, compare
// flags and status.
// An item is taken only when the block is idle; s_axis_tready stays low
// until the result word has been taken from the output register.
// Cross products use one 32x32 multiplier, one product a cycle; reduction
// is a Euclidean gcd where each remainder step runs on a shared radix-2
// divider, followed by two divides by the gcd. The worst case is about 90
// gcd steps. Compare skips the gcd and the divides; errors and unused op
// codes go from decode straight to the output register.
// Reset clears the sequencer and the output valid.
// When the receiver stalls, the result holds in m_axis_tdata/tuser and
// no new input word is taken.
module rational_arithmetic_unit
	import rau_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata, // operation, a_num, a_den, b_num, b_den, zero fill
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata, // result_num, result_den, zero fill
	output logic [4:0]   m_axis_tuser  // less, equal, greater, status
);
	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_MUL1, S_MUL2, S_MUL3, S_FORM, S_GCD, S_GCDW,
		S_DIVN, S_DIVNW, S_DIVD, S_DIVDW, S_FIN, S_OUT
	} state_t;

	state_t state_q;
	logic [2:0] op_q;
	logic [WORD_BITS-1:0] an_q, ad_q, bn_q, bd_q;
	logic an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
	logic [MAG_BITS-1:0] p1_q, p2_q, p3_q;
	logic [MAG_BITS-1:0] nmag_q, d_q, gx_q, gy_q;
	logic nneg_q;
	logic [31:0] rnum_q;
	logic [30:0] rden_q;
	logic lt_q, eq_q, gt_q;
	status_t st_q;
	logic out_v_q;

	logic [WORD_BITS-1:0] mul_a, mul_b;
	logic [MAG_BITS-1:0] mul_p;
	logic dv_start, dv_done;
	logic [MAG_BITS-1:0] dv_a, dv_b;
	div_res_t dv_res;

	logic sa, sb, qneg;
	logic [MAG_BITS-1:0] lim;

	function automatic logic [WORD_BITS-1:0] mag_of(input logic [31:0] v);
		logic [WORD_BITS-1:0] w;
		w = v[WORD_BITS-1:0];
		return w[WORD_BITS-1] ? (~w + 1'b1) : w;
	endfunction

	assign mul_p = MAG_BITS'(mul_a) * MAG_BITS'(mul_b);
	assign sa = an_neg_q ^ ad_neg_q;
	assign sb = bn_neg_q ^ bd_neg_q;
	assign qneg = (op_q == OP_SUB) ? !sb : sb;
	assign lim = (MAG_BITS'(1) << (WORD_BITS - 1)) - MAG_BITS'(1);

	always_comb begin
		mul_a = an_q;
		mul_b = bd_q;
		case (state_q)
			S_MUL1: begin
				mul_a = an_q;
				mul_b = (op_q == OP_MUL) ? bn_q : bd_q;
			end
			S_MUL2: begin
				mul_a = bn_q;
				mul_b = ad_q;
			end
			S_MUL3: begin
				mul_a = ad_q;
				mul_b = (op_q == OP_DIV) ? bn_q : bd_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		dv_start = 1'b0;
		dv_a = gx_q;
		dv_b = gy_q;
		case (state_q)
			S_GCD: dv_start = (gy_q != '0);
			S_DIVN: begin
				dv_start = 1'b1;
				dv_a = nmag_q;
				dv_b = gx_q;
			end
			S_DIVD: begin
				dv_start = 1'b1;
				dv_a = d_q;
				dv_b = gx_q;
			end
			default: ;
		endcase
	end

	rau_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (dv_a),
		.divisor  (dv_b),
		.done     (dv_done),
		.res      (dv_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q <= s_axis_tdata[2:0];
						an_q <= s_axis_tdata[3 +: WORD_BITS];
						ad_q <= s_axis_tdata[35 +: WORD_BITS];
						bn_q <= s_axis_tdata[67 +: WORD_BITS];
						bd_q <= s_axis_tdata[99 +: WORD_BITS];
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					an_neg_q <= an_q[WORD_BITS-1];
					ad_neg_q <= ad_q[WORD_BITS-1];
					bn_neg_q <= bn_q[WORD_BITS-1];
					bd_neg_q <= bd_q[WORD_BITS-1];
					an_q <= mag_of(32'(an_q));
					ad_q <= mag_of(32'(ad_q));
					bn_q <= mag_of(32'(bn_q));
					bd_q <= mag_of(32'(bd_q));
					rnum_q <= '0;
					rden_q <= 31'd1;
					lt_q <= 1'b0;
					eq_q <= 1'b0;
					gt_q <= 1'b0;
					st_q <= ST_OK;
					if (op_q > 3'(OP_CMP)) begin
						state_q <= S_OUT;
					end else if (ad_q == '0 || bd_q == '0) begin
						st_q <= ST_ZERO_DEN;
						state_q <= S_OUT;
					end else if (op_q == 3'(OP_DIV) && bn_q == '0) begin
						st_q <= ST_DIV_ZERO;
						state_q <= S_OUT;
					end else begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					p1_q <= mul_p;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					p2_q <= mul_p;
					state_q <= S_MUL3;
				end
				S_MUL3: begin
					p3_q <= mul_p;
					state_q <= (op_q == 3'(OP_CMP)) ? S_FIN : S_FORM;
				end
				S_FORM: begin
					d_q <= p3_q;
					gy_q <= p3_q;
					if (op_q == 3'(OP_MUL) || op_q == 3'(OP_DIV)) begin
						nneg_q <= sa ^ sb;
						nmag_q <= p1_q;
						gx_q <= p1_q;
					end else if (sa == qneg) begin
						nneg_q <= sa;
						nmag_q <= p1_q + p2_q;
						gx_q <= p1_q + p2_q;
					end else if (p1_q >= p2_q) begin
						nneg_q <= sa;
						nmag_q <= p1_q - p2_q;
						gx_q <= p1_q - p2_q;
					end else begin
						nneg_q <= qneg;
						nmag_q <= p2_q - p1_q;
						gx_q <= p2_q - p1_q;
					end
					state_q <= S_GCD;
				end
				S_GCD: begin
					state_q <= (gy_q == '0) ? S_DIVN : S_GCDW;
				end
				S_GCDW: begin
					if (dv_done) begin
						gx_q <= gy_q;
						gy_q <= dv_res.rem;
						state_q <= S_GCD;
					end
				end
				S_DIVN: state_q <= S_DIVNW;
				S_DIVNW: begin
					if (dv_done) begin
						nmag_q <= dv_res.quot;
						state_q <= S_DIVD;
					end
				end
				S_DIVD: state_q <= S_DIVDW;
				S_DIVDW: begin
					if (dv_done) begin
						d_q <= dv_res.quot;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (op_q == 3'(OP_CMP)) begin
						if (p1_q == '0 && p2_q == '0) begin
							eq_q <= 1'b1;
						end else if (p1_q == '0) begin
							lt_q <= !sb;
							gt_q <= sb;
						end else if (p2_q == '0) begin
							lt_q <= sa;
							gt_q <= !sa;
						end else if (sa != sb) begin
							lt_q <= sa;
							gt_q <= sb;
						end else if (p1_q == p2_q) begin
							eq_q <= 1'b1;
						end else begin
							lt_q <= sa ? (p1_q > p2_q) : (p1_q < p2_q);
							gt_q <= sa ? (p1_q < p2_q) : (p1_q > p2_q);
						end
					end else if (d_q > lim ||
							nmag_q > lim + MAG_BITS'(nneg_q && nmag_q != '0)) begin
						st_q <= ST_OVERFLOW;
					end else begin
						rnum_q <= 32'(signed'((nneg_q && nmag_q != '0) ?
							(~nmag_q[WORD_BITS-1:0] + 1'b1) : nmag_q[WORD_BITS-1:0]));
						rden_q <= 31'(d_q);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_v_q) begin
						out_v_q <= 1'b1;
					end else if (m_axis_tready) begin
						out_v_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {1'b0, rden_q, rnum_q};
	assign m_axis_tuser = {st_q, gt_q, eq_q, lt_q};
endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
	import rau_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [2:0]  operation;
		logic [31:0] a_num;
		logic [31:0] a_den;
		logic [31:0] b_num;
		logic [31:0] b_den;
	} frac_pair_t;

	typedef struct {
		logic [31:0] result_num;
		logic [30:0] result_den;
		logic        less;
		logic        equal;
		logic        greater;
		logic [1:0]  status;
	} frac_result_t;

	localparam int N_RANDOM = 1830;
	localparam int HOLD_CYCLES = 400;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;
	logic [4:0]   m_axis_tuser;

	frac_pair_t   pending_words[$];
	frac_result_t expected_results[$];
	frac_pair_t   held_word;
	int           accepted_cnt = 0;
	int           total_items = 0;
	int           hold_cnt = 0;
	bit           hold_done = 1'b0;
	bit           failed = 1'b0;

	rational_arithmetic_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #1 clk = ~clk;

	function automatic longint unsigned magnitude(logic [31:0] v);
		return v[31] ? (64'h1_0000_0000 - {32'b0, v}) : {32'b0, v};
	endfunction

	function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic frac_result_t compute_fraction(frac_pair_t w);
		frac_result_t r;
		longint unsigned an, ad, bn, bd, pm, qm, nm, d, g, lim;
		bit sa, sb, pn, qn, nn;
		r = '{result_num: 32'd0, result_den: 31'd1, less: 1'b0, equal: 1'b0,
			greater: 1'b0, status: ST_OK};
		an = magnitude(w.a_num);
		ad = magnitude(w.a_den);
		bn = magnitude(w.b_num);
		bd = magnitude(w.b_den);
		sa = w.a_num[31] != w.a_den[31];
		sb = w.b_num[31] != w.b_den[31];
		if (w.operation > OP_CMP)
			return r;
		if (ad == 0 || bd == 0) begin
			r.status = ST_ZERO_DEN;
			return r;
		end
		if (w.operation == OP_CMP) begin
			pm = an * bd;
			qm = bn * ad;
			pn = sa && pm != 0;
			qn = sb && qm != 0;
			if (pn != qn) begin
				r.less = pn;
				r.greater = !pn;
			end else if (pm == qm) begin
				r.equal = 1'b1;
			end else begin
				r.less = pn ? (pm > qm) : (pm < qm);
				r.greater = !r.less;
			end
			return r;
		end
		if (w.operation == OP_DIV && bn == 0) begin
			r.status = ST_DIV_ZERO;
			return r;
		end
		if (w.operation == OP_ADD || w.operation == OP_SUB) begin
			pm = an * bd;
			pn = sa;
			qm = bn * ad;
			qn = (w.operation == OP_SUB) ? !sb : sb;
			if (pn == qn) begin
				nn = pn;
				nm = pm + qm;
			end else if (pm >= qm) begin
				nn = pn;
				nm = pm - qm;
			end else begin
				nn = qn;
				nm = qm - pm;
			end
			d = ad * bd;
		end else if (w.operation == OP_MUL) begin
			nn = sa != sb;
			nm = an * bn;
			d = ad * bd;
		end else begin
			nn = sa != sb;
			nm = an * bd;
			d = ad * bn;
		end
		g = euclid_gcd(nm, d);
		nm = nm / g;
		d = d / g;
		if (nm == 0)
			nn = 1'b0;
		lim = 64'h7FFF_FFFF;
		if (d > lim || nm > lim + (nn ? 1 : 0)) begin
			r.status = ST_OVERFLOW;
		end else begin
			r.result_num = nn ? 32'(64'd0 - nm) : nm[31:0];
			r.result_den = d[30:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] pick_value();
		int k;
		k = $urandom_range(99);
		if (k < 6)
			return $urandom();
		if (k < 12)
			return 32'($signed(16'($urandom())));
		if (k < 16)
			return 32'd0;
		if (k < 18) begin
			case ($urandom_range(3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'hFFFF_FFFF;
				default: return 32'd1;
			endcase
		end
		return 32'($signed($urandom_range(200)) - 100);
	endfunction

	function automatic bit sender_idles();
		if (accepted_cnt < total_items / 3)
			return $urandom_range(99) < 22;
		if (accepted_cnt < 2 * total_items / 3)
			return $urandom_range(99) < 81;
		return 1'b0;
	endfunction

	function automatic bit receiver_idles();
		if (accepted_cnt < total_items / 3)
			return $urandom_range(99) < 81;
		if (accepted_cnt < 2 * total_items / 3)
			return $urandom_range(99) < 22;
		return 1'b0;
	endfunction

	// driver: advance only when the current word is taken or none is offered
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(compute_fraction(held_word));
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_words.size() > 0 && !sender_idles()) begin
					held_word = pending_words.pop_front();
					s_axis_tdata <= {5'b0, held_word.b_den, held_word.b_num,
						held_word.a_den, held_word.a_num, held_word.operation};
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver readiness, with one long hold-off at the start of the last phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && total_items > 0 && accepted_cnt >= 2 * total_items / 3) begin
			hold_done <= 1'b1;
			hold_cnt <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !receiver_idles();
		end
	end

	// monitor
	always @(posedge clk) begin
		frac_result_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result word %h %h", m_axis_tdata, m_axis_tuser);
				failed = 1'b1;
			end else begin
				e = expected_results.pop_front();
				if (m_axis_tdata[31:0] !== e.result_num) begin
					$error("result_num expected %h actual %h", e.result_num, m_axis_tdata[31:0]);
					failed = 1'b1;
				end
				if (m_axis_tdata[62:32] !== e.result_den) begin
					$error("result_den expected %h actual %h", e.result_den, m_axis_tdata[62:32]);
					failed = 1'b1;
				end
				if (m_axis_tuser[0] !== e.less) begin
					$error("less expected %b actual %b", e.less, m_axis_tuser[0]);
					failed = 1'b1;
				end
				if (m_axis_tuser[1] !== e.equal) begin
					$error("equal expected %b actual %b", e.equal, m_axis_tuser[1]);
					failed = 1'b1;
				end
				if (m_axis_tuser[2] !== e.greater) begin
					$error("greater expected %b actual %b", e.greater, m_axis_tuser[2]);
					failed = 1'b1;
				end
				if (m_axis_tuser[4:3] !== e.status) begin
					$error("status expected %h actual %h", e.status, m_axis_tuser[4:3]);
					failed = 1'b1;
				end
			end
		end
	end

	task automatic add_word(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
		logic [31:0] bn, logic [31:0] bd);
		pending_words.push_back('{operation: op, a_num: an, a_den: ad, b_num: bn, b_den: bd});
	endtask

	initial begin
		logic [2:0] op;
		logic [31:0] ad, bd;
		add_word(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
		add_word(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
		add_word(OP_MUL, -32'sd3, 32'd4, 32'd2, -32'sd9);
		add_word(OP_DIV, 32'd5, -32'sd6, -32'sd10, 32'd3);
		add_word(OP_CMP, 32'd1, 32'd2, 32'd2, 32'd4);
		add_word(OP_CMP, -32'sd1, 32'd2, 32'd1, -32'sd3);
		add_word(OP_CMP, 32'd1, -32'sd2, 32'd0, 32'd5);
		add_word(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd2);
		add_word(OP_CMP, 32'd1, 32'd2, 32'd1, 32'd0);
		add_word(OP_DIV, 32'd3, 32'd0, 32'd0, 32'd1);
		add_word(OP_DIV, 32'd3, 32'd4, 32'd0, -32'sd7);
		add_word(OP_DIV, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1);
		add_word(OP_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
		add_word(OP_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
		add_word(OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0000, 32'h8000_0000);
		add_word(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		add_word(OP_CMP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		add_word(OP_MUL, 32'd0, 32'h8000_0000, 32'd5, 32'd7);
		add_word(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1);
		add_word(3'd5, 32'd1, 32'd2, 32'd3, 32'd4);
		add_word(3'd6, 32'd1, 32'd0, 32'd3, 32'd0);
		add_word(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		for (int i = 0; i < N_RANDOM; i++) begin
			op = ($urandom_range(99) < 4) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
			ad = pick_value();
			bd = pick_value();
			if (ad == 0 && $urandom_range(3) != 0)
				ad = 32'd1;
			if (bd == 0 && $urandom_range(3) != 0)
				bd = 32'd1;
			add_word(op, pick_value(), ad, pick_value(), bd);
		end
		total_items = pending_words.size();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_words.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (!failed && expected_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("Some tests failed");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/rau_pkg.sv
rtl/core/rau_divider.sv
rtl/core/rational_arithmetic_unit.sv
tb/sv/tb_top.sv
